@@ sv/mml_pkg.sv @@
// Package for the music-macro string parser: payload structs, phase codes,
// tone table and helpers. No dependencies.
package mml_pkg;

	typedef struct packed {
		logic [7:0] music_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic        event_kind;
		logic [10:0] tone_hz;
		logic [13:0] length_ms;
		logic        last_of_run;
	} out_item_t;

	// job handed from the parser to the duration/frequency back end
	typedef struct packed {
		logic        kind;      // 0 tone, 1 rest
		logic [3:0]  semi;
		logic [2:0]  oct;
		logic [6:0]  len;
		logic [7:0]  tempo;
		logic        dotted;
		logic        last;
	} job_t;

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_NOTE      = 4'd1;
	localparam logic [3:0] PH_NOTE_ACC  = 4'd2;
	localparam logic [3:0] PH_NOTE_DIG  = 4'd3;
	localparam logic [3:0] PH_OCT       = 4'd4;
	localparam logic [3:0] PH_LEN       = 4'd5;
	localparam logic [3:0] PH_TEMPO     = 4'd6;
	localparam logic [3:0] PH_PAUSE     = 4'd7;
	localparam logic [3:0] PH_PAUSE_DIG = 4'd8;
	localparam logic [3:0] PH_NUM       = 4'd9;
	localparam logic [3:0] PH_STYLE     = 4'd10;

	localparam logic       KIND_TONE = 1'b0;
	localparam logic       KIND_REST = 1'b1;
	localparam logic [9:0] ACC_MAX   = 10'd1023;
	localparam logic [17:0] MS_NUM   = 18'd240000;

	function automatic logic [9:0] base_hz(input logic [3:0] s);
		case (s)
			4'd0:    base_hz = 10'd262;
			4'd1:    base_hz = 10'd277;
			4'd2:    base_hz = 10'd294;
			4'd3:    base_hz = 10'd311;
			4'd4:    base_hz = 10'd330;
			4'd5:    base_hz = 10'd349;
			4'd6:    base_hz = 10'd370;
			4'd7:    base_hz = 10'd392;
			4'd8:    base_hz = 10'd415;
			4'd9:    base_hz = 10'd440;
			4'd10:   base_hz = 10'd466;
			4'd11:   base_hz = 10'd494;
			default: base_hz = 10'd0;
		endcase
	endfunction

	function automatic logic [3:0] letter_semi(input logic [2:0] l);
		case (l)
			3'd0:    letter_semi = 4'd9;
			3'd1:    letter_semi = 4'd11;
			3'd2:    letter_semi = 4'd0;
			3'd3:    letter_semi = 4'd2;
			3'd4:    letter_semi = 4'd4;
			3'd5:    letter_semi = 4'd5;
			3'd6:    letter_semi = 4'd7;
			default: letter_semi = 4'd0;
		endcase
	endfunction

	function automatic logic [10:0] tone_freq(input logic [3:0] s, input logic [2:0] o);
		logic [13:0] f;
		f = {4'd0, base_hz(s)};
		if (o < 3'd4) f = f >> (3'd4 - o);
		else          f = f << (o - 3'd4);
		tone_freq = (f > 14'd2047) ? 11'd2047 : f[10:0];
	endfunction

endpackage

@@ sv/mml_front.sv @@
// Front end: classifies each byte, keeps the parse state and pushes up to
// two event jobs per byte. Depends on mml_pkg.
module mml_front #(
	parameter int TOP_OCTAVE = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  mml_pkg::in_item_t in_data,
	output logic              job_valid,
	input  logic              job_stall,
	output mml_pkg::job_t     job_data
);
	import mml_pkg::*;

	localparam logic [2:0] TOP_OCT = 3'(TOP_OCTAVE);

	logic [3:0] phase_q;
	logic [2:0] oct_q;
	logic [6:0] dlen_q;
	logic [7:0] tempo_q;
	logic [3:0] semi_q;
	logic       dot_q;
	logic [9:0] acc_q;

	// second job of a byte waits here
	logic       hold_valid_q;
	job_t       hold_q;

	assign in_stall = hold_valid_q || (job_valid && job_stall);

	logic [7:0] c;
	logic       dig, dig19;
	logic [3:0] dval;
	logic [9:0] acc_add;
	logic [13:0] acc_mul;

	always_comb begin
		c = in_data.music_byte;
		if (c >= 8'h61 && c <= 8'h7a) c = c - 8'd32;
		dig   = c >= 8'h30 && c <= 8'h39;
		dig19 = c >= 8'h31 && c <= 8'h39;
		dval  = c[3:0];
		acc_mul = {4'd0, acc_q} * 14'd10 + {10'd0, dval};
		acc_add = (acc_mul > {4'd0, ACC_MAX}) ? ACC_MAX : acc_mul[9:0];
	end

	// finish helper: a given length of 1..64, else the default length
	function automatic logic [6:0] vlen(input logic [9:0] n, input logic [6:0] d);
		vlen = (n >= 10'd1 && n <= 10'd64) ? n[6:0] : d;
	endfunction

	// split a note index (0..83) into {octave, semitone} by parallel compares
	function automatic logic [6:0] split_num(input logic [9:0] m);
		logic [2:0] o;
		logic [9:0] r;
		o = 3'd0;
		for (int k = 1; k < 7; k++) begin
			if (m >= 10'(12 * k)) o = 3'(k);
		end
		r = m - ({4'd0, o, 3'd0} + {5'd0, o, 2'd0});
		split_num = {o, r[3:0]};
	endfunction

	logic [3:0] n_phase;
	logic [2:0] n_oct;
	logic [6:0] n_dlen;
	logic [7:0] n_tempo;
	logic [3:0] n_semi;
	logic       n_dot;
	logic [9:0] n_acc;
	logic       used;
	job_t       jobs [2];
	logic [1:0] njobs;

	always_comb begin
		job_t j;
		logic [9:0] nm;
		n_phase = phase_q; n_oct = oct_q; n_dlen = dlen_q; n_tempo = tempo_q;
		n_semi = semi_q; n_dot = dot_q; n_acc = acc_q;
		used = 1'b0;
		njobs = 2'd0;
		jobs[0] = '0; jobs[1] = '0;
		j = '0;
		nm = 10'd0;

		// extend
		case (phase_q)
			PH_NOTE, PH_NOTE_ACC, PH_NOTE_DIG: begin
				if (phase_q == PH_NOTE && (c == 8'h23 || c == 8'h2b)) begin
					n_semi = (semi_q >= 4'd11) ? 4'd0 : semi_q + 4'd1;
					n_phase = PH_NOTE_ACC; used = 1'b1;
				end else if (phase_q == PH_NOTE && c == 8'h2d) begin
					n_semi = (semi_q == 4'd0) ? 4'd11 : semi_q - 4'd1;
					n_phase = PH_NOTE_ACC; used = 1'b1;
				end else if (phase_q != PH_NOTE_DIG && dig19) begin
					n_acc = {6'd0, dval}; n_phase = PH_NOTE_DIG; used = 1'b1;
				end else if (phase_q == PH_NOTE_DIG && dig) begin
					n_acc = acc_add; used = 1'b1;
				end else if (c == 8'h2e) begin
					used = 1'b1; n_dot = 1'b1;
				end
			end
			PH_OCT: begin
				if (c >= 8'h30 && c <= 8'h30 + {5'd0, TOP_OCT}) begin
					n_oct = c[2:0]; n_phase = PH_IDLE; used = 1'b1;
				end
			end
			PH_PAUSE: begin
				if (dig19) begin
					n_acc = {6'd0, dval}; n_phase = PH_PAUSE_DIG; used = 1'b1;
				end
			end
			PH_LEN, PH_TEMPO, PH_PAUSE_DIG, PH_NUM: begin
				if (dig) begin n_acc = acc_add; used = 1'b1; end
			end
			PH_STYLE: begin
				if (c == 8'h4e || c == 8'h4c || c == 8'h53) begin
					n_phase = PH_IDLE; used = 1'b1;
				end
			end
			default: ;
		endcase

		// dot finishes the note right away; otherwise finish and restart
		// when the byte was not used; end of string finishes once more
		for (int pass = 0; pass < 2; pass++) begin
			logic do_fin;
			do_fin = 1'b0;
			if (pass == 0) do_fin = (!used) || (used && n_dot && !dot_q);
			else           do_fin = in_data.end_of_string;
			if (do_fin) begin
				j = '0;
				j.tempo = n_tempo; j.dotted = n_dot; j.oct = n_oct; j.semi = n_semi;
				case (n_phase)
					PH_NOTE, PH_NOTE_ACC, PH_NOTE_DIG: begin
						j.kind = KIND_TONE;
						j.len = (n_phase == PH_NOTE_DIG) ? vlen(n_acc, n_dlen) : n_dlen;
						jobs[njobs[0]] = j; njobs = njobs + 2'd1;
					end
					PH_LEN: if (n_acc >= 10'd1 && n_acc <= 10'd64) n_dlen = n_acc[6:0];
					PH_TEMPO: if (n_acc >= 10'd32 && n_acc <= 10'd255) n_tempo = n_acc[7:0];
					PH_PAUSE, PH_PAUSE_DIG: begin
						j.kind = KIND_REST; j.dotted = 1'b0;
						j.len = (n_phase == PH_PAUSE) ? n_dlen : vlen(n_acc, n_dlen);
						jobs[njobs[0]] = j; njobs = njobs + 2'd1;
					end
					PH_NUM: begin
						j.len = n_dlen; j.dotted = 1'b0;
						if (n_acc == 10'd0) begin
							j.kind = KIND_REST;
							jobs[njobs[0]] = j; njobs = njobs + 2'd1;
						end else if (n_acc <= 10'd84) begin
							nm = n_acc - 10'd1;
							j.kind = KIND_TONE;
							{j.oct, j.semi} = split_num(nm);
							jobs[njobs[0]] = j; njobs = njobs + 2'd1;
						end
					end
					default: ;
				endcase
				n_phase = PH_IDLE; n_dot = 1'b0; n_acc = 10'd0;
				if (pass == 0 && !used) begin
					if (c >= 8'h41 && c <= 8'h47) begin
						n_semi = letter_semi(c[2:0] - 3'd1); n_phase = PH_NOTE;
					end else if (c == 8'h4f) n_phase = PH_OCT;
					else if (c == 8'h3e) begin
						if (n_oct < TOP_OCT) n_oct = n_oct + 3'd1;
					end else if (c == 8'h3c) begin
						if (n_oct > 3'd0) n_oct = n_oct - 3'd1;
					end else if (c == 8'h4c) n_phase = PH_LEN;
					else if (c == 8'h54) n_phase = PH_TEMPO;
					else if (c == 8'h50) n_phase = PH_PAUSE;
					else if (c == 8'h4e) n_phase = PH_NUM;
					else if (c == 8'h4d) n_phase = PH_STYLE;
				end
			end
		end
		if (in_data.end_of_string) begin
			n_phase = PH_IDLE; n_oct = 3'd4; n_dlen = 7'd4; n_tempo = 8'd120;
			n_semi = 4'd0; n_dot = 1'b0; n_acc = 10'd0;
		end
		if (njobs == 2'd1) jobs[0].last = 1'b1;
		if (njobs == 2'd2) jobs[1].last = 1'b1;
	end

	logic take;
	assign take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; oct_q <= 3'd4; dlen_q <= 7'd4; tempo_q <= 8'd120;
			semi_q <= 4'd0; dot_q <= 1'b0; acc_q <= 10'd0;
			job_valid <= 1'b0; hold_valid_q <= 1'b0;
		end else begin
			// a held job implies a head job, so it advances once the head transfers
			if (hold_valid_q && !job_stall) begin
				job_valid <= 1'b1; job_data <= hold_q; hold_valid_q <= 1'b0;
			end else if (take && njobs != 2'd0) begin
				job_valid <= 1'b1; job_data <= jobs[0];
				if (njobs == 2'd2) begin hold_valid_q <= 1'b1; hold_q <= jobs[1]; end
			end else if (job_valid && !job_stall) begin
				job_valid <= 1'b0;
			end
			if (take) begin
				phase_q <= n_phase; oct_q <= n_oct; dlen_q <= n_dlen; tempo_q <= n_tempo;
				semi_q <= n_semi; dot_q <= n_dot; acc_q <= n_acc;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> job_valid) else $error("held job without head job");
	assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_data.end_of_string) |=> (phase_q == PH_IDLE && oct_q == 3'd4))
		else $error("state not restored at end of string");
	assert property (@(posedge clk) disable iff (!arst_n)
		oct_q <= TOP_OCT) else $error("octave above top");
endmodule

@@ sv/mml_back.sv @@
// Back end: a two-entry job queue, then an iterative divider for the
// duration and a tone lookup. Depends on mml_pkg.
module mml_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_stall,
	input  mml_pkg::job_t      job_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mml_pkg::out_item_t out_data
);
	import mml_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	job_t       fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	logic [1:0]  st_q;
	job_t        cur_q;
	logic [14:0] div_q;
	logic [17:0] quo_q;
	logic [17:0] rem_q;
	logic [4:0]  bit_q;

	assign job_stall = (cnt_q == 2'd2);
	assign push = job_valid && !job_stall;
	assign pop  = (st_q == ST_IDLE) && (cnt_q != 2'd0);

	logic [18:0] trial;
	logic [13:0] ms, ms_d;
	always_comb begin
		trial = {rem_q, quo_q[17]} - {4'd0, div_q};
		ms = quo_q[13:0];
		ms_d = cur_q.dotted ? ms + {1'b0, ms[13:1]} : ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0; st_q <= ST_IDLE; out_valid <= 1'b0;
		end else begin
			if (push) begin fifo_q[wp_q] <= job_data; wp_q <= !wp_q; end
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			// drop the valid after a transfer unless a new result replaces it
			if (out_valid && !out_stall && st_q != ST_DONE) out_valid <= 1'b0;
			case (st_q)
				ST_IDLE: if (pop) begin cur_q <= fifo_q[rp_q]; st_q <= ST_MUL; end
				ST_MUL: begin
					div_q <= {7'd0, cur_q.tempo} * {8'd0, cur_q.len};
					quo_q <= MS_NUM; rem_q <= 18'd0; bit_q <= 5'd18; st_q <= ST_DIV;
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					if (div_q == 15'd0) begin
						quo_q <= MS_NUM; bit_q <= 5'd0;
					end else if (!trial[18]) begin
						rem_q <= trial[17:0]; quo_q <= {quo_q[16:0], 1'b1};
					end else begin
						rem_q <= {rem_q[16:0], quo_q[17]}; quo_q <= {quo_q[16:0], 1'b0};
					end
					bit_q <= bit_q - 5'd1;
					if (bit_q == 5'd1 || div_q == 15'd0) st_q <= ST_DONE;
				end
				ST_DONE: if (!out_valid || !out_stall) begin
					out_valid <= 1'b1;
					out_data.event_kind  <= cur_q.kind;
					out_data.tone_hz     <= (cur_q.kind == KIND_REST) ? 11'd0
						: tone_freq(cur_q.semi, cur_q.oct);
					out_data.length_ms   <= ms_d;
					out_data.last_of_run <= cur_q.last;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && (!out_valid || !out_stall)) |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> st_q == ST_IDLE) else $error("pop while busy");
endmodule

@@ sv/mml_music_string_parser_unit.sv @@
// Music-macro string parser, top level. An input transfer passes the parser
// register, queue write, load, multiply, up to 18 divider steps and the output
// register before its first result is valid; a second event of the same byte
// follows through the same steps. The back end works on one event at a time.
// Reset (arst_n low) returns octave 4, length 4, tempo 120 and empties queues.
// Depends on mml_pkg, mml_front, mml_back.
module mml_music_string_parser_unit #(
	parameter int TOP_OCTAVE = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mml_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output mml_pkg::out_item_t out_data
);
	import mml_pkg::*;

	logic job_valid, job_stall;
	job_t job_data;

	mml_front #(.TOP_OCTAVE(TOP_OCTAVE)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.job_valid, .job_stall, .job_data
	);

	mml_back u_back (
		.clk, .arst_n, .job_valid, .job_stall, .job_data,
		.out_valid, .out_stall, .out_data
	);
endmodule
